// ----- design/wtrm_pkg.sv -----
package wtrm_pkg;

    // Width of the reported rate
    localparam int OUT_W = 58;
    // Width and reset value of the window register
    localparam int WINDOW_W = 16;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd3000;
    // Milliseconds per second, and the number of samples never evicted
    localparam int MS_PER_S = 1000;
    localparam int MIN_KEEP = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_APPEND,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_OLD_CMP,
        ST_DIV,
        ST_FINISH
    } wtrm_state_t;

    // Which ring entry the history RAM reads
    typedef enum logic [1:0] {
        RD_NEWEST,
        RD_SECOND,
        RD_OLDEST
    } wtrm_rd_sel_t;

    typedef struct packed {
        logic         capture;
        logic         clear;
        logic         drop;
        logic         append;
        wtrm_rd_sel_t rd_sel;
        logic         div_start;
        logic         zero_rate;
        logic         load_out;
    } wtrm_cmd_t;

    typedef struct packed {
        logic restart;
        logic full;
        logic many;
        logic expired;
        logic rate_ok;
        logic div_done;
        logic out_free;
    } wtrm_status_t;

endpackage

// ----- design/wtrm_if.sv -----
// Sample channel: one beat is a time stamp and a cumulative byte count
interface wtrm_sample_if #(
    parameter int VALUE_BITS = 48
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] now_ms;
    logic [VALUE_BITS-1:0] byte_count;

    modport source (output valid, output now_ms, output byte_count, input ready);
    modport sink   (input valid, input now_ms, input byte_count, output ready);
endinterface

// Rate channel: one beat per accepted sample
interface wtrm_rate_if import wtrm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] bytes_per_second;

    modport source (output valid, output bytes_per_second, input ready);
    modport sink   (input valid, input bytes_per_second, output ready);
endinterface

// Configuration channel: window length write
interface wtrm_cfg_if import wtrm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WINDOW_W-1:0] window_ms;

    modport source (output valid, output window_ms, input ready);
    modport sink   (input valid, input window_ms, output ready);
endinterface

// ----- design/windowed_transfer_rate_meter_top.sv -----
// Sliding-window transfer rate meter. Each sample beat carries a time stamp in
// ms and a cumulative byte count; each produces exactly one rate beat in whole
// bytes per second over the window set by window_ms (reset 3000). A byte count
// below the newest stored one restarts the history; the history holds DEPTH
// samples and a full history drops its oldest. One sample is processed at a
// time: after the sample is accepted, the history is checked and the sample
// appended, the oldest sample is evicted while more than two are held and the
// one after it lies outside the window, and the rate is divided out by a
// bit-serial restoring divider or set to zero. The next sample is accepted in
// the cycle after the rate beat is loaded. The rate beat sits in an output
// register, so the next sample is accepted while it waits; a sample only
// stalls in its final state while an earlier beat is still waiting. window_ms
// must be written by the user only while no sample is in flight; the block
// itself does not enforce it.
module windowed_transfer_rate_meter_top import wtrm_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    wtrm_sample_if.sink  sample,
    wtrm_rate_if.source  rate,
    wtrm_cfg_if.sink     cfg
);

    wtrm_cmd_t    cmd;
    wtrm_status_t status;
    logic         in_ready;

    // Window register is always writable
    assign cfg.ready    = 1'b1;
    assign sample.ready = in_ready;

    wtrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wtrm_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .now_ms     (sample.now_ms),
        .byte_count (sample.byte_count),
        .cfg_we     (cfg.valid),
        .cfg_window (cfg.window_ms),
        .out_ready  (rate.ready),
        .out_valid  (rate.valid),
        .out_rate   (rate.bytes_per_second)
    );

endmodule

// ----- design/wtrm_ram.sv -----
module wtrm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/wtrm_div.sv -----
module wtrm_div import wtrm_pkg::*; #(
    parameter int VALUE_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] diff,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [OUT_W-1:0]      quot
);

    // Scaled dividend needs 10 more bits than the difference (1000 < 1024)
    localparam int PW    = VALUE_BITS + 10;
    localparam int CNT_W = $clog2(PW + 1);

    logic                  mul_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [VALUE_BITS-1:0] diff_reg;
    logic [VALUE_BITS-1:0] dvsr_reg;
    logic [PW-1:0]         prod_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [OUT_W-1:0]      q_reg;
    logic                  sat_reg;

    logic [VALUE_BITS:0]   trial;
    logic                  fits;
    logic [VALUE_BITS-1:0] rem_step;

    // One restoring step: bring down the next dividend bit, try the subtract
    always_comb
    begin
        trial    = {rem_reg, prod_reg[PW-1]};
        fits     = trial >= {1'b0, dvsr_reg};
        rem_step = fits ? VALUE_BITS'(trial - {1'b0, dvsr_reg}) : trial[VALUE_BITS-1:0];
    end

    // Sequencing: operand load, scale by 1000, then one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            mul_reg  <= start;
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (mul_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(PW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Operand and quotient registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            diff_reg <= diff;
            dvsr_reg <= divisor;
        end
        if (mul_reg)
        begin
            prod_reg <= PW'(diff_reg) * PW'(MS_PER_S);
            rem_reg  <= '0;
            q_reg    <= '0;
            sat_reg  <= 1'b0;
        end
        else if (run_reg)
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            rem_reg  <= rem_step;
            q_reg    <= {q_reg[OUT_W-2:0], fits};
            // quotient would outgrow the output width: clamp at the end
            sat_reg  <= sat_reg | q_reg[OUT_W-1];
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? '1 : q_reg;

endmodule

// ----- design/wtrm_datapath.sv -----
module wtrm_datapath import wtrm_pkg::*; #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wtrm_cmd_t             cmd,
    output wtrm_status_t          status,
    input  logic [VALUE_BITS-1:0] now_ms,
    input  logic [VALUE_BITS-1:0] byte_count,
    input  logic                  cfg_we,
    input  logic [WINDOW_W-1:0]   cfg_window,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [OUT_W-1:0]      out_rate
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Ring position of the entry 'off' places after the oldest
    function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    logic [WINDOW_W-1:0]   window_reg;
    logic [IW-1:0]         oldest_reg;
    logic [IW-1:0]         oldest_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [VALUE_BITS-1:0] now_reg;
    logic [VALUE_BITS-1:0] bytes_reg;
    logic [OUT_W-1:0]      result_reg;
    logic                  out_valid_reg;
    logic [OUT_W-1:0]      out_rate_reg;

    logic [IW-1:0]           raddr;
    logic [IW-1:0]           waddr;
    logic [IW-1:0]           second_pos;
    logic [CW-1:0]           newest_off;
    logic [2*VALUE_BITS-1:0] rdata;
    logic [VALUE_BITS-1:0]   rd_time;
    logic [VALUE_BITS-1:0]   rd_bytes;
    logic                    div_done;
    logic [OUT_W-1:0]        div_quot;

    // History RAM: time stamp in the upper half, byte count in the lower
    wtrm_ram #(
        .WIDTH (2 * VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (waddr),
        .wdata ({now_reg, bytes_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_time  = rdata[2*VALUE_BITS-1:VALUE_BITS];
    assign rd_bytes = rdata[VALUE_BITS-1:0];

    // Ring addressing
    always_comb
    begin
        newest_off = (count_reg == '0) ? '0 : count_reg - CW'(1);
        second_pos = ring_pos(oldest_reg, CW'(1));
        waddr      = ring_pos(oldest_reg, count_reg);
        unique case (cmd.rd_sel)
            RD_NEWEST: raddr = ring_pos(oldest_reg, newest_off);
            RD_SECOND: raddr = second_pos;
            RD_OLDEST: raddr = oldest_reg;
            default:   raddr = oldest_reg;
        endcase
    end

    // Ring pointer update
    always_comb
    begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        if (cmd.clear)
        begin
            oldest_next = '0;
            count_next  = '0;
        end
        else if (cmd.drop)
        begin
            oldest_next = second_pos;
            count_next  = count_reg - CW'(1);
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // Rate unit
    wtrm_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .diff    (bytes_reg - rd_bytes),
        .divisor (now_reg - rd_time),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Status back to the controller
    always_comb
    begin
        status.restart  = (count_reg != '0) && (bytes_reg < rd_bytes);
        status.full     = count_reg == CW'(DEPTH);
        status.many     = count_reg > CW'(MIN_KEEP);
        status.expired  = ((VALUE_BITS + 1)'(rd_time) + (VALUE_BITS + 1)'(window_reg))
                          <= (VALUE_BITS + 1)'(now_reg);
        status.rate_ok  = (now_reg > rd_time) && (bytes_reg >= rd_bytes);
        status.div_done = div_done;
        status.out_free = !out_valid_reg || out_ready;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            oldest_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_window;
            end
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample, result and output beat registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg   <= now_ms;
            bytes_reg <= byte_count;
        end
        if (cmd.zero_rate)
        begin
            result_reg <= '0;
        end
        else if (div_done)
        begin
            result_reg <= div_quot;
        end
        if (cmd.load_out)
        begin
            out_rate_reg <= result_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rate  = out_rate_reg;

endmodule

// ----- design/wtrm_ctrl.sv -----
module wtrm_ctrl import wtrm_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  wtrm_status_t status,
    output wtrm_cmd_t    cmd
);

    wtrm_state_t state_reg;
    wtrm_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_OLDEST;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                // keep the newest entry on the read port for the restart check
                in_ready   = 1'b1;
                cmd.rd_sel = RD_NEWEST;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // restart clears the history; otherwise a full ring loses its oldest
                cmd.clear  = status.restart;
                cmd.drop   = !status.restart && status.full;
                state_next = ST_APPEND;
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_WALK_RD;
            end
            ST_WALK_RD:
            begin
                if (status.many)
                begin
                    cmd.rd_sel = RD_SECOND;
                    state_next = ST_WALK_CMP;
                end
                else
                begin
                    state_next = ST_OLD_CMP;
                end
            end
            ST_WALK_CMP:
            begin
                if (status.expired)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    state_next = ST_OLD_CMP;
                end
            end
            ST_OLD_CMP:
            begin
                if (status.rate_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.zero_rate = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
